// ===== design/tss_pkg.sv =====
// shared types, constants and saturation helper for the tridiagonal solver
// no dependencies
package tss_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int IDX_W     = $clog2(MAX_ROWS);
    localparam int CNT_W     = $clog2(MAX_ROWS + 1);
    localparam int PROD_W    = 2 * WORD_W;
    localparam int WIDE_W    = PROD_W + 2;
    localparam int NUM_W     = WORD_W + FRAC_BITS;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    function automatic word_t sat_word(input wide_t v);
        word_t res;
        if (v > WIDE_W'(WORD_MAX)) begin
            res = WORD_MAX;
        end
        else if (v < WIDE_W'(WORD_MIN)) begin
            res = WORD_MIN;
        end
        else begin
            res = v[WORD_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== design/tss_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module tss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/tss_divider.sv =====
// iterative restoring divider: sat((num * 2^FRAC_BITS) / den), truncated toward zero
// depends on tss_pkg
module tss_divider (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  tss_pkg::word_t num,
    input  tss_pkg::word_t den,
    output logic          done,
    output tss_pkg::word_t quot
);
    import tss_pkg::*;

    localparam int ITER_W = $clog2(NUM_W + 1);

    logic                busy_reg, busy_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [NUM_W-1:0]    dq_reg, dq_next;
    logic [WORD_W:0]     rem_reg, rem_next;
    logic [WORD_W-1:0]   den_reg, den_next;
    logic                neg_reg, neg_next;
    logic                done_reg, done_next;
    word_t               quot_reg, quot_next;
    logic [WORD_W-1:0]   num_mag, den_mag;
    logic [WORD_W:0]     trial;
    logic [WORD_W:0]     diff;
    logic [NUM_W-1:0]    q_final;
    wide_t               q_signed;

    assign num_mag = num[WORD_W-1] ? (~num + 1'b1) : num;
    assign den_mag = den[WORD_W-1] ? (~den + 1'b1) : den;

    assign trial   = {rem_reg[WORD_W-1:0], dq_reg[NUM_W-1]};
    assign diff    = trial - {1'b0, den_reg};
    assign q_final = {dq_reg[NUM_W-2:0], ~diff[WORD_W]};
    assign q_signed = neg_reg ? -WIDE_W'(q_final) : WIDE_W'(q_final);

    always_comb
    begin
        busy_next = busy_reg;
        iter_next = iter_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            dq_next   = {num_mag, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            den_next  = den_mag;
            neg_next  = num[WORD_W-1] ^ den[WORD_W-1];
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            if (!diff[WORD_W])
            begin
                rem_next = diff;
            end
            else
            begin
                rem_next = trial;
            end
            dq_next   = q_final;
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                quot_next = sat_word(q_signed);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== design/tridiagonal_system_solver_core.sv =====
// top level of the tridiagonal solver: sequencer, shared multiplier, stores
// depends on tss_pkg, tss_ram, tss_divider

// Solves a tridiagonal system by the Thomas algorithm in signed Q16.16, one row
// per input transaction. Each row passes the states S_MUL1, S_MUL2 and S_MUL3
// around two multiplies on the shared 32x32 multiplier, then two 48-step
// divisions on the one bit-serial divider (one quotient bit per cycle), the
// store state and a return to idle; a zero pivot skips the divisions. The input
// is stalled while a row is in work. After the row marked last (or the 64th
// row), back substitution runs S_BS_RD, S_BS_MUL and S_BS_SUB per row through
// the store RAM, and the solution is then emitted from index 0 upward, one
// element at a time, each held while the output is stalled.
// No clearing pass follows reset.
module tridiagonal_system_solver_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  tss_pkg::word_t               lower_coef,
    input  tss_pkg::word_t               diag_coef,
    input  tss_pkg::word_t               upper_coef,
    input  tss_pkg::word_t               rhs_value,
    input  logic                         last_row,
    output logic                         out_valid,
    input  logic                         out_stall,
    output tss_pkg::word_t               solution_value,
    output logic [tss_pkg::IDX_W-1:0]    solution_index,
    output logic                         last_result
);
    import tss_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL1   = 4'd1;
    localparam logic [3:0] S_MUL2   = 4'd2;
    localparam logic [3:0] S_MUL3   = 4'd3;
    localparam logic [3:0] S_DIVE   = 4'd4;
    localparam logic [3:0] S_DIVR   = 4'd5;
    localparam logic [3:0] S_STORE  = 4'd6;
    localparam logic [3:0] S_BS_RD  = 4'd7;
    localparam logic [3:0] S_BS_MUL = 4'd8;
    localparam logic [3:0] S_BS_SUB = 4'd9;
    localparam logic [3:0] S_OUT_RD = 4'd10;
    localparam logic [3:0] S_OUT_LD = 4'd11;
    localparam logic [3:0] S_OUT_WT = 4'd12;

    logic [3:0]              state_reg, state_next;
    logic [CNT_W-1:0]        row_count_reg, row_count_next;
    logic                    out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]        idx_reg, j_reg, j_next, k_reg, k_next;
    logic                    last_reg;
    word_t                   c_reg, d_reg, e_reg, r_reg;
    word_t                   ep_prev_reg, rp_prev_reg, ep_new_reg, rp_new_reg;
    word_t                   piv_reg, num_reg, x_reg;
    word_t                   out_value_reg;
    logic [IDX_W-1:0]        out_index_reg;
    logic                    out_last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    word_t                   mul_a, mul_b;
    wide_t                   shifted;
    logic [IDX_W-1:0]        idx_in;
    logic                    accept;

    // stores: {modified upper, modified rhs} and the solution
    logic                    pr_we, pr_re, sol_we, sol_re;
    logic [IDX_W-1:0]        pr_raddr, sol_waddr;
    logic [2*WORD_W-1:0]     pr_rdata;
    word_t                   sol_wdata;
    logic [WORD_W-1:0]       sol_rdata;
    word_t                   ep_rd, rp_rd;

    logic                    div_start, div_done;
    word_t                   div_num, div_quot;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign idx_in   = (row_count_reg >= CNT_W'(MAX_ROWS)) ? IDX_W'(MAX_ROWS - 1)
                                                          : row_count_reg[IDX_W-1:0];
    assign ep_rd    = pr_rdata[2*WORD_W-1:WORD_W];
    assign rp_rd    = pr_rdata[WORD_W-1:0];
    assign shifted  = WIDE_W'(prod_reg >>> FRAC_BITS);

    tss_ram #(.WIDTH(2 * WORD_W), .DEPTH(MAX_ROWS)) u_prime_ram (
        .clk   (clk),
        .we    (pr_we),
        .waddr (idx_reg),
        .wdata ({ep_new_reg, rp_new_reg}),
        .re    (pr_re),
        .raddr (pr_raddr),
        .rdata (pr_rdata)
    );

    tss_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ROWS)) u_sol_ram (
        .clk   (clk),
        .we    (sol_we),
        .waddr (sol_waddr),
        .wdata (sol_wdata),
        .re    (sol_re),
        .raddr (k_reg),
        .rdata (sol_rdata)
    );

    assign div_num   = (state_reg == S_MUL3) ? e_reg : num_reg;
    assign div_start = ((state_reg == S_MUL3) && (piv_reg != '0))
                       || ((state_reg == S_DIVE) && div_done);

    tss_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (piv_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // shared multiplier operand select
    always_comb
    begin
        mul_a = ep_rd;
        mul_b = x_reg;
        case (state_reg)
            S_MUL1:
            begin
                mul_a = (idx_reg == '0) ? '0 : ep_prev_reg;
                mul_b = c_reg;
            end
            S_MUL2:
            begin
                mul_a = (idx_reg == '0) ? '0 : rp_prev_reg;
                mul_b = c_reg;
            end
            default:
            begin
                mul_a = ep_rd;
                mul_b = x_reg;
            end
        endcase
    end

    assign pr_we     = (state_reg == S_STORE);
    assign pr_re     = (state_reg == S_BS_RD);
    assign pr_raddr  = j_reg - 1'b1;
    assign sol_we    = (state_reg == S_STORE) || (state_reg == S_BS_SUB);
    assign sol_waddr = (state_reg == S_STORE) ? idx_reg : (j_reg - 1'b1);
    assign sol_wdata = (state_reg == S_STORE) ? rp_new_reg
                                              : sat_word(WIDE_W'(rp_rd) - shifted);
    assign sol_re    = (state_reg == S_OUT_RD);

    always_comb
    begin
        state_next     = state_reg;
        row_count_next = row_count_reg;
        out_valid_next = out_valid_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_MUL3;
            S_MUL3:  state_next = (piv_reg == '0) ? S_STORE : S_DIVE;
            S_DIVE:
            begin
                if (div_done)
                begin
                    state_next = S_DIVR;
                end
            end
            S_DIVR:
            begin
                if (div_done)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                if (last_reg)
                begin
                    row_count_next = '0;
                    j_next         = idx_reg;
                    k_next         = '0;
                    state_next     = (idx_reg == '0) ? S_OUT_RD : S_BS_RD;
                end
                else
                begin
                    row_count_next = CNT_W'(idx_reg) + 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_BS_RD:  state_next = S_BS_MUL;
            S_BS_MUL: state_next = S_BS_SUB;
            S_BS_SUB:
            begin
                j_next     = j_reg - 1'b1;
                state_next = (j_reg == IDX_W'(1)) ? S_OUT_RD : S_BS_RD;
            end
            S_OUT_RD: state_next = S_OUT_LD;
            S_OUT_LD:
            begin
                out_valid_next = 1'b1;
                state_next     = S_OUT_WT;
            end
            S_OUT_WT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (k_reg == idx_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_count_reg <= row_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg <= j_next;
        k_reg <= k_next;
        if (accept)
        begin
            c_reg    <= lower_coef;
            d_reg    <= diag_coef;
            r_reg    <= rhs_value;
            idx_reg  <= idx_in;
            last_reg <= last_row || (idx_in == IDX_W'(MAX_ROWS - 1));
            e_reg    <= (last_row || (idx_in == IDX_W'(MAX_ROWS - 1))) ? '0 : upper_coef;
        end
        if ((state_reg == S_MUL1) || (state_reg == S_MUL2) || (state_reg == S_BS_MUL))
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == S_MUL2)
        begin
            piv_reg <= sat_word(WIDE_W'(d_reg) - shifted);
        end
        if (state_reg == S_MUL3)
        begin
            num_reg <= sat_word(WIDE_W'(r_reg) - shifted);
            if (piv_reg == '0)
            begin
                ep_new_reg <= '0;
                rp_new_reg <= '0;
            end
        end
        if ((state_reg == S_DIVE) && div_done)
        begin
            ep_new_reg <= div_quot;
        end
        if ((state_reg == S_DIVR) && div_done)
        begin
            rp_new_reg <= div_quot;
        end
        if (state_reg == S_STORE)
        begin
            ep_prev_reg <= ep_new_reg;
            rp_prev_reg <= rp_new_reg;
            x_reg       <= rp_new_reg;
        end
        if (state_reg == S_BS_SUB)
        begin
            x_reg <= sol_wdata;
        end
        if (state_reg == S_OUT_LD)
        begin
            out_value_reg <= sol_rdata;
            out_index_reg <= k_reg;
            out_last_reg  <= (k_reg == idx_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign solution_value = out_value_reg;
    assign solution_index = out_index_reg;
    assign last_result    = out_last_reg;

`ifndef ASSERT_OFF
    // results only appear while the input side is held off
    assert property (@(posedge clk) disable iff (!rst_n) !in_stall |-> !out_valid)
        else $error("output transaction pending while idle");
    // the divider is never started on a zero pivot
    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> piv_reg != '0)
        else $error("division started with zero pivot");
    // row counter stays within the store
    assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg < CNT_W'(MAX_ROWS))
        else $error("row counter out of range");
    // the last flag rides exactly on the highest row index
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_result |-> solution_index == idx_reg)
        else $error("last flag on wrong solution element");
`endif

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for tridiagonal_system_solver_core: directed rows, full store, random systems
// depends on tss_pkg and the solver core; a thomas-algorithm predictor gives the expected values
module tb_top;
    import tss_pkg::*;

    typedef struct {
        word_t      value;
        logic [5:0] index;
        logic       last;
    } sol_t;

    typedef struct {
        word_t lower;
        word_t diag;
        word_t upper;
        word_t rhs;
        logic  last;
        logic  has_exp;
        word_t exp_value;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    word_t lower_coef = '0;
    word_t diag_coef = '0;
    word_t upper_coef = '0;
    word_t rhs_value = '0;
    logic last_row = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    word_t solution_value;
    logic [IDX_W-1:0] solution_index;
    logic last_result;

    // predictor state
    word_t ep_mem [MAX_ROWS];
    word_t rp_mem [MAX_ROWS];
    int rows_in_system = 0;
    sol_t expected_solutions[$];
    int typed_value_q[$];
    int errors = 0;
    bit hold_out = 1'b0;
    row_t directed[$];

    tridiagonal_system_solver_core u_dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint sat64(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor shift of a 64-bit product
    function automatic longint fshr(longint x);
        return x >>> FRAC_BITS;
    endfunction

    function automatic longint qdiv(longint num, longint piv);
        longint s;
        s = num * 65536;
        return sat64(s / piv);
    endfunction

    task automatic solve_row(input row_t r);
        int idx;
        bit lst;
        longint c, e, ep_prev, rp_prev, piv, num, p;
        word_t sol [MAX_ROWS];
        sol_t s;
        idx = rows_in_system;
        lst = r.last;
        c = r.lower;
        e = r.upper;
        ep_prev = 0;
        rp_prev = 0;
        if (idx + 1 >= MAX_ROWS) lst = 1'b1;
        if (idx > 0)
        begin
            ep_prev = ep_mem[idx-1];
            rp_prev = rp_mem[idx-1];
        end
        if (lst) e = 0;
        piv = sat64(longint'(r.diag) - fshr(ep_prev * c));
        num = sat64(longint'(r.rhs) - fshr(rp_prev * c));
        if (piv != 0)
        begin
            ep_mem[idx] = word_t'(qdiv(e, piv));
            rp_mem[idx] = word_t'(qdiv(num, piv));
        end
        else
        begin
            ep_mem[idx] = '0;
            rp_mem[idx] = '0;
        end
        if (!lst)
        begin
            rows_in_system = idx + 1;
            return;
        end
        sol[idx] = rp_mem[idx];
        for (int j = idx; j > 0; j--)
        begin
            p = longint'(ep_mem[j-1]) * longint'(sol[j]);
            sol[j-1] = word_t'(sat64(longint'(rp_mem[j-1]) - fshr(p)));
        end
        for (int j = 0; j <= idx; j++)
        begin
            s.value = sol[j];
            s.index = j[5:0];
            s.last = (j == idx);
            expected_solutions.push_back(s);
        end
        rows_in_system = 0;
    endtask

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    function automatic word_t rand_word(int mode);
        case (mode)
            0: return word_t'($urandom);
            1: return word_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: return word_t'($urandom_range(32'h0001_0000, 32'h0008_0000));
        endcase
    endfunction

    task automatic drive_row(input row_t r);
        lower_coef <= r.lower;
        diag_coef <= r.diag;
        upper_coef <= r.upper;
        rhs_value <= r.rhs;
        last_row <= r.last;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        solve_row(r);
        if (r.has_exp) typed_value_q.push_back(r.exp_value);
    endtask

    task automatic gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 120) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic row_t mk(word_t l, word_t d, word_t u, word_t r, logic lst,
                                logic he, word_t ev);
        row_t x;
        x.lower = l; x.diag = d; x.upper = u; x.rhs = r; x.last = lst;
        x.has_exp = he; x.exp_value = ev;
        return x;
    endfunction

    // output side: random stall, checking
    always @(posedge clk)
    begin
        sol_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_solutions.size() == 0)
                report("unexpected solution", solution_value, 0);
            else
            begin
                w = expected_solutions.pop_front();
                if (solution_value !== w.value) report("value", solution_value, w.value);
                if (solution_index !== w.index) report("index", solution_index, w.index);
                if (last_result !== w.last) report("last", last_result, w.last);
                if (w.index == 0 && typed_value_q.size() > 0)
                begin
                    if (solution_value !== word_t'(typed_value_q[0]))
                        report("typed value", solution_value, typed_value_q[0]);
                    void'(typed_value_q.pop_front());
                end
            end
        end
        if (hold_out) out_stall <= 1'b1;
        else if ($urandom_range(0, 19) == 0) out_stall <= 1'b1;
        else if ($urandom_range(0, 2) == 0) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 3) == 0);
    end

    // long hold-off on the receiver while rows keep coming
    initial
    begin
        repeat (3000) @(posedge clk);
        hold_out = 1'b1;
        repeat (6000) @(posedge clk);
        hold_out = 1'b0;
    end

    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int n, mode;
        row_t r;
        // single-row systems: x = r/d, values readable at a glance
        directed.push_back(mk(32'sh7fff_ffff, 32'sh0001_0000, 32'sh1234_5678, 32'sh0003_0000,
                              1'b1, 1'b1, 32'sh0003_0000));
        directed.push_back(mk(0, 32'sh0002_0000, 0, 32'sh0004_0000, 1'b1, 1'b1, 32'sh0002_0000));
        // zero pivot
        directed.push_back(mk(0, 0, 32'sh0001_0000, 32'sh7fff_ffff, 1'b1, 1'b1, 0));
        // saturating quotients, then most-negative d and r giving 1.0
        directed.push_back(mk(0, 32'sh0000_0001, 0, 32'sh7fff_ffff, 1'b1, 1'b1, 32'sh7fff_ffff));
        directed.push_back(mk(0, 32'sh0000_0001, 0, 32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000));
        directed.push_back(mk(0, 32'sh8000_0000, 0, 32'sh8000_0000, 1'b1, 1'b1, 32'sh0001_0000));
        // multi-row systems with extremes
        directed.push_back(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                              32'sh7fff_ffff, 1'b0, 1'b0, 0));
        directed.push_back(mk(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                              32'sh8000_0000, 1'b0, 1'b0, 0));
        directed.push_back(mk(32'shffff_ffff, 32'sh0004_0000, 32'shffff_ffff,
                              32'sh0001_0000, 1'b1, 1'b0, 0));
        directed.push_back(mk(0, 32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0, 1'b0, 0));
        directed.push_back(mk(32'sh0002_0000, 32'sh0001_0000, 0, 32'sh0002_0000, 1'b0, 1'b0, 0));
        directed.push_back(mk(32'sh0001_0000, 32'sh0003_0000, 0, 32'shfffe_0000, 1'b1, 1'b0, 0));
        for (int k = 0; k < MAX_ROWS; k++)
        begin
            ep_mem[k] = '0;
            rp_mem[k] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[k])
        begin
            drive_row(directed[k]);
            gap();
        end
        // full-store system: 64 rows, never marked last
        for (int k = 0; k < MAX_ROWS; k++)
        begin
            r = mk(rand_word(1), rand_word(2), rand_word(1), rand_word(0), 1'b0, 1'b0, 0);
            drive_row(r);
            if (k % 16 == 0) gap();
        end
        // random systems, mostly small
        n = 0;
        while (n < 110)
        begin
            int len;
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 4);
            mode = $urandom_range(0, 4);
            for (int k = 0; k < len; k++)
            begin
                r = mk(rand_word(mode == 0 ? 0 : 1), rand_word(mode == 0 ? 0 : mode == 1 ? 1 : 2),
                       rand_word(mode == 0 ? 0 : 1), rand_word(mode < 2 ? 0 : 1),
                       k == len - 1, 1'b0, 0);
                if ($urandom_range(0, 15) == 0) r.diag = '0;
                drive_row(r);
                gap();
                n++;
            end
        end
        in_valid <= 1'b0;
        while (expected_solutions.size() > 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (errors == 0 && expected_solutions.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
